// ===== design/power_meter_window_average_defines.svh =====
// Assertion macros shared by the power meter RTL.
`ifndef POWER_METER_WINDOW_AVERAGE_DEFINES_SVH
`define POWER_METER_WINDOW_AVERAGE_DEFINES_SVH
`ifndef ASSERT_OFF
// Property that must hold at every edge outside reset.
`define PMWA_ASSERT(lbl, clock, rstn, prop, msg) \
    lbl: assert property (@(posedge clock) disable iff (!rstn) (prop)) else $error(msg);
// Implication whose consequent is checked in the next cycle.
`define PMWA_ASSERT_NEXT(lbl, clock, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clock) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PMWA_ASSERT(lbl, clock, rstn, prop, msg)
`define PMWA_ASSERT_NEXT(lbl, clock, rstn, ante, cons, msg)
`endif
`endif

// ===== design/pmwa_pkg.sv =====
// Shared constants of the power meter.
`default_nettype none
package pmwa_pkg;
    localparam int DEPTH_DEF       = 64;
    localparam int SAMPLE_BITS_DEF = 10;
    localparam int MUL_B_W         = 18;
    localparam int N_OUT_W         = 7;
    localparam int MEAN_W          = 33;
    localparam int POWER_W         = 48;
    localparam int WIN_W           = 7;
    localparam int SCALE_W         = 16;
    localparam int OFFS_W          = 32;
endpackage
`default_nettype wire

// ===== design/pmwa_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
`default_nettype none
module pmwa_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule
`default_nettype wire

// ===== design/pmwa_mul.sv =====
// Shared signed multiplier with registered product.
`default_nettype none
module pmwa_mul
    import pmwa_pkg::*;
#(
    parameter int MA_W = 33
) (
    input  logic                           clk,
    input  logic signed [MA_W-1:0]         a,
    input  logic signed [MUL_B_W-1:0]      b,
    output logic signed [MA_W+MUL_B_W-1:0] p
);
    logic signed [MA_W+MUL_B_W-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= a * b;
    end

    assign p = p_reg;
endmodule
`default_nettype wire

// ===== design/pmwa_div.sv =====
// Restoring unsigned divider, one quotient bit a cycle.
`default_nettype none
module pmwa_div #(
    parameter int DIV_W = 56,
    parameter int DVS_W = 7
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DIV_W-1:0] quotient,
    output logic [DVS_W-1:0] remainder
);
    localparam int CW = $clog2(DIV_W + 1);

    logic [DVS_W:0]   rem_reg, rem_next;
    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [DVS_W-1:0] dvs_reg;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DVS_W:0]   shifted;
    logic             ge;

    assign shifted = {rem_reg[DVS_W-1:0], quo_reg[DIV_W-1]};
    assign ge      = shifted >= {1'b0, dvs_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            cnt_next  = CW'(DIV_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? (shifted - {1'b0, dvs_reg}) : shifted;
            quo_next = {quo_reg[DIV_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
        begin
            dvs_reg <= divisor;
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg[DVS_W-1:0];
endmodule
`default_nettype wire

// ===== design/power_meter_window_average.sv =====
// Top level of the windowed average power meter.
//
//  channel | dir | transfer / contents
//  s_*     | in  | tuser = func; tdata = current_sample, voltage_sample
//  m_*     | out | tuser = valid_res; tdata = n, mean I, mean V, mean P
//  apb     | in  | 5 registers at 4*i, written in the access phase
//
// For each averaged pair a query does one RAM read, four passes through the
// shared multiplier and two adds, then the two scalings and the three
// divides by n in the serial divider, then loads the output register; an
// empty ring goes straight to loading the output register.
// Reset clears pointer, fill count and control registers; the RAM is never cleared,
// only the newest fill-count entries are read. A waiting result does not
// stop stores; a finished query holds in its last state until m_tready.
`default_nettype none
`include "power_meter_window_average_defines.svh"
module power_meter_window_average
    import pmwa_pkg::*;
#(
    parameter int DEPTH       = DEPTH_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [SB-1:0] current_sample, [2SB-1:SB] voltage_sample, zero pad
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
    // [0] func
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [6:0] samples_used, [39:7] mean_current, [72:40] mean_voltage,
    // [120:73] mean_power, [127:121] zero
    output logic [127:0] m_tdata,
    // [0] valid_res
    output logic         m_tuser,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    localparam int SB     = SAMPLE_BITS;
    localparam int AW     = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CC_W   = ((SB + 16 > 31) ? SB + 16 : 31) + 2;
    localparam int MP_W   = CC_W + MUL_B_W;
    localparam int PR_W   = 2 * CC_W;
    localparam int SP_W   = 2 * CC_W - 17 + CNT_W;
    localparam int SC_W   = SB + CNT_W;
    localparam int DIV_W  = SP_W;
    localparam int EXT_W  = (SP_W + 1 > POWER_W + 1) ? SP_W + 1 : POWER_W + 1;
    localparam int PAD_IN = ((2*SB+7)/8)*8 - 2*SB;

    // register indexes
    localparam logic [2:0] R_WIN  = 3'd0;
    localparam logic [2:0] R_CSC  = 3'd1;
    localparam logic [2:0] R_COFF = 3'd2;
    localparam logic [2:0] R_VSC  = 3'd3;
    localparam logic [2:0] R_VOFF = 3'd4;

    // sequencer states
    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_RD    = 5'd1;
    localparam logic [4:0] ST_MC    = 5'd2;
    localparam logic [4:0] ST_MV    = 5'd3;
    localparam logic [4:0] ST_ADDV  = 5'd4;
    localparam logic [4:0] ST_MLO   = 5'd5;
    localparam logic [4:0] ST_MHI   = 5'd6;
    localparam logic [4:0] ST_PADD  = 5'd7;
    localparam logic [4:0] ST_PACC  = 5'd8;
    localparam logic [4:0] ST_MULC  = 5'd9;
    localparam logic [4:0] ST_SDIVC = 5'd10;
    localparam logic [4:0] ST_WDIVC = 5'd11;
    localparam logic [4:0] ST_MULV  = 5'd12;
    localparam logic [4:0] ST_SDIVV = 5'd13;
    localparam logic [4:0] ST_WDIVV = 5'd14;
    localparam logic [4:0] ST_SDIVP = 5'd15;
    localparam logic [4:0] ST_WDIVP = 5'd16;
    localparam logic [4:0] ST_OUT   = 5'd17;

    localparam logic signed [MEAN_W-1:0]  MAX33 = {1'b0, {(MEAN_W-1){1'b1}}};
    localparam logic signed [MEAN_W-1:0]  MIN33 = {1'b1, {(MEAN_W-1){1'b0}}};
    localparam logic signed [POWER_W-1:0] MAX48 = {1'b0, {(POWER_W-1){1'b1}}};
    localparam logic signed [POWER_W-1:0] MIN48 = {1'b1, {(POWER_W-1){1'b0}}};

    // configuration
    logic [WIN_W-1:0]          win_reg;
    logic [SCALE_W-1:0]        csc_reg, vsc_reg;
    logic signed [OFFS_W-1:0]  coff_reg, voff_reg;
    logic                      cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg  <= WIN_W'(64);
            csc_reg  <= SCALE_W'(320);
            coff_reg <= '0;
            vsc_reg  <= SCALE_W'(320);
            voff_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (paddr[4:2])
                R_WIN:   win_reg  <= pwdata[WIN_W-1:0];
                R_CSC:   csc_reg  <= pwdata[SCALE_W-1:0];
                R_COFF:  coff_reg <= pwdata;
                R_VSC:   vsc_reg  <= pwdata[SCALE_W-1:0];
                R_VOFF:  voff_reg <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            R_WIN:   prdata = 32'(win_reg);
            R_CSC:   prdata = 32'(csc_reg);
            R_COFF:  prdata = coff_reg;
            R_VSC:   prdata = 32'(vsc_reg);
            R_VOFF:  prdata = voff_reg;
            default: prdata = '0;
        endcase
    end

    // control state
    logic [4:0]       state_reg, state_next;
    logic [AW-1:0]    wp_reg, idx_reg;
    logic [CNT_W-1:0] fill_reg, n_reg, cnt_reg;
    logic             m_valid_reg;

    // datapath registers
    logic [SC_W-1:0]          sumc_reg, sumv_reg;
    logic signed [SP_W-1:0]   sump_reg;
    logic [SB-1:0]            vs_reg;
    logic signed [CC_W-1:0]   cc_reg, vc_reg;
    logic signed [MP_W-1:0]   lo_reg;
    logic signed [PR_W-1:0]   prod_reg;
    logic signed [MEAN_W-1:0] mc_reg, mv_reg;
    logic signed [POWER_W-1:0] mp_reg;
    logic [127:0]             m_data_reg;
    logic                     m_user_reg;

    logic s_acc, m_load;
    logic [SB-1:0] cs_in, vs_in, cs_rd, vs_rd;
    logic [2*SB-1:0] rdata;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign m_load   = (state_reg == ST_OUT) && (!m_valid_reg || m_tready);
    assign cs_in    = s_tdata[SB-1:0];
    assign vs_in    = s_tdata[2*SB-1:SB];
    assign cs_rd    = rdata[SB-1:0];
    assign vs_rd    = rdata[2*SB-1:SB];

    // effective window and pairs taken: clamp to 1..DEPTH, then to fill
    logic [CNT_W-1:0] win_eff, n_q;
    always_comb
    begin
        if (win_reg == '0)
        begin
            win_eff = CNT_W'(1);
        end
        else if (int'(win_reg) > DEPTH)
        begin
            win_eff = CNT_W'(DEPTH);
        end
        else
        begin
            win_eff = CNT_W'(win_reg);
        end
        n_q = (win_eff < fill_reg) ? win_eff : fill_reg;
    end

    function automatic logic [AW-1:0] ring_dec(input logic [AW-1:0] x);
        ring_dec = (x == '0) ? AW'(DEPTH - 1) : x - 1'b1;
    endfunction

    pmwa_ram #(.WIDTH(2*SB), .DEPTH(DEPTH)) u_ram (
        .clk   (clk),
        .we    (s_acc && !s_tuser),
        .waddr (wp_reg),
        .wdata ({vs_in, cs_in}),
        .re    (state_reg == ST_RD),
        .raddr (idx_reg),
        .rdata (rdata)
    );

    // shared multiplier operand select
    logic signed [CC_W-1:0]    mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MP_W-1:0]    mres;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_MC:
            begin
                mul_a = $signed(CC_W'(csc_reg));
                mul_b = $signed(MUL_B_W'(cs_rd));
            end
            ST_MV:
            begin
                mul_a = $signed(CC_W'(vsc_reg));
                mul_b = $signed(MUL_B_W'(vs_reg));
            end
            ST_MLO:
            begin
                mul_a = cc_reg;
                mul_b = $signed({1'b0, vc_reg[16:0]});
            end
            ST_MHI:
            begin
                mul_a = cc_reg;
                mul_b = MUL_B_W'(vc_reg >>> 17);
            end
            ST_MULC:
            begin
                mul_a = $signed(CC_W'(sumc_reg));
                mul_b = $signed(MUL_B_W'(csc_reg));
            end
            ST_MULV:
            begin
                mul_a = $signed(CC_W'(sumv_reg));
                mul_b = $signed(MUL_B_W'(vsc_reg));
            end
            default: ;
        endcase
    end

    pmwa_mul #(.MA_W(CC_W)) u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mres)
    );

    // shared divider by n
    logic             div_start, div_done;
    logic [DIV_W-1:0] div_dvd, div_q;
    logic [CNT_W-1:0] div_r;
    logic             p_neg;

    assign p_neg     = sump_reg < 0;
    assign div_start = (state_reg == ST_SDIVC) || (state_reg == ST_SDIVV)
                    || (state_reg == ST_SDIVP);
    always_comb
    begin
        if (state_reg == ST_SDIVP)
        begin
            div_dvd = DIV_W'(p_neg ? -sump_reg : sump_reg);
        end
        else
        begin
            div_dvd = DIV_W'($unsigned(mres));
        end
    end

    pmwa_div #(.DIV_W(DIV_W), .DVS_W(CNT_W)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dvd),
        .divisor   (n_reg),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    // quotient plus offset, saturated to 33 bits
    logic signed [DIV_W:0]  mean_sum;
    logic signed [OFFS_W-1:0] off_sel;
    logic signed [MEAN_W-1:0] mean_sat;
    assign off_sel  = (state_reg == ST_WDIVC) ? coff_reg : voff_reg;
    assign mean_sum = $signed({1'b0, div_q}) + (DIV_W+1)'(off_sel);
    always_comb
    begin
        if (mean_sum > (DIV_W+1)'(MAX33))
        begin
            mean_sat = MAX33;
        end
        else if (mean_sum < (DIV_W+1)'(MIN33))
        begin
            mean_sat = MIN33;
        end
        else
        begin
            mean_sat = MEAN_W'(mean_sum);
        end
    end

    // floor quotient of the power sum, saturated to 48 bits
    logic signed [EXT_W-1:0]   pq;
    logic signed [POWER_W-1:0] power_sat;
    always_comb
    begin
        pq = $signed(EXT_W'(div_q));
        if (p_neg)
        begin
            pq = -(pq + EXT_W'(div_r != '0));
        end
        if (pq > EXT_W'(MAX48))
        begin
            power_sat = MAX48;
        end
        else if (pq < EXT_W'(MIN48))
        begin
            power_sat = MIN48;
        end
        else
        begin
            power_sat = POWER_W'(pq);
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_acc && s_tuser)
                begin
                    state_next = (n_q == '0) ? ST_OUT : ST_RD;
                end
            end
            ST_RD:    state_next = ST_MC;
            ST_MC:    state_next = ST_MV;
            ST_MV:    state_next = ST_ADDV;
            ST_ADDV:  state_next = ST_MLO;
            ST_MLO:   state_next = ST_MHI;
            ST_MHI:   state_next = ST_PADD;
            ST_PADD:  state_next = ST_PACC;
            ST_PACC:  state_next = (cnt_reg == CNT_W'(1)) ? ST_MULC : ST_RD;
            ST_MULC:  state_next = ST_SDIVC;
            ST_SDIVC: state_next = ST_WDIVC;
            ST_WDIVC: state_next = div_done ? ST_MULV : ST_WDIVC;
            ST_MULV:  state_next = ST_SDIVV;
            ST_SDIVV: state_next = ST_WDIVV;
            ST_WDIVV: state_next = div_done ? ST_SDIVP : ST_WDIVV;
            ST_SDIVP: state_next = ST_WDIVP;
            ST_WDIVP: state_next = div_done ? ST_OUT : ST_WDIVP;
            ST_OUT:   state_next = m_load ? ST_IDLE : ST_OUT;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            wp_reg      <= '0;
            fill_reg    <= '0;
            idx_reg     <= '0;
            n_reg       <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (s_acc && !s_tuser)
            begin
                wp_reg <= (wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
                if (fill_reg < CNT_W'(DEPTH))
                begin
                    fill_reg <= fill_reg + 1'b1;
                end
            end
            if (s_acc && s_tuser)
            begin
                n_reg   <= n_q;
                cnt_reg <= n_q;
                idx_reg <= ring_dec(wp_reg);
            end
            if (state_reg == ST_PACC)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                idx_reg <= ring_dec(idx_reg);
            end
            if (m_load)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (s_acc && s_tuser)
        begin
            sumc_reg <= '0;
            sumv_reg <= '0;
            sump_reg <= '0;
            mc_reg   <= '0;
            mv_reg   <= '0;
            mp_reg   <= '0;
        end
        case (state_reg)
            ST_MC:
            begin
                vs_reg   <= vs_rd;
                sumc_reg <= sumc_reg + SC_W'(cs_rd);
                sumv_reg <= sumv_reg + SC_W'(vs_rd);
            end
            ST_MV:    cc_reg   <= CC_W'(mres) + CC_W'(coff_reg);
            ST_ADDV:  vc_reg   <= CC_W'(mres) + CC_W'(voff_reg);
            ST_MHI:   lo_reg   <= mres;
            ST_PADD:  prod_reg <= PR_W'(lo_reg) + (PR_W'(mres) <<< 17);
            ST_PACC:  sump_reg <= sump_reg + SP_W'(prod_reg >>> 16);
            ST_WDIVC:
            begin
                if (div_done)
                begin
                    mc_reg <= mean_sat;
                end
            end
            ST_WDIVV:
            begin
                if (div_done)
                begin
                    mv_reg <= mean_sat;
                end
            end
            ST_WDIVP:
            begin
                if (div_done)
                begin
                    mp_reg <= power_sat;
                end
            end
            default: ;
        endcase
        if (m_load)
        begin
            m_data_reg <= {7'b0, mp_reg, mv_reg, mc_reg, N_OUT_W'(n_reg)};
            m_user_reg <= (n_reg != '0);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    // pad bits of the input word carry nothing
    logic unused_pad;
    if (PAD_IN > 0)
    begin : g_pad
        assign unused_pad = ^s_tdata[((2*SB+7)/8)*8-1:2*SB];
    end
    else
    begin : g_nopad
        assign unused_pad = 1'b0;
    end

    `PMWA_ASSERT(a_fill_bound, clk, rst_n, fill_reg <= CNT_W'(DEPTH), "fill count above depth")
    `PMWA_ASSERT(a_loop_count, clk, rst_n, (state_reg != ST_RD) || (cnt_reg != '0 && cnt_reg <= n_reg), "pair loop count out of range")
    `PMWA_ASSERT_NEXT(a_hold_result, clk, rst_n, state_reg == ST_OUT && m_valid_reg && !m_tready, state_reg == ST_OUT, "result dropped while output stalled")
    `PMWA_ASSERT_NEXT(a_query_start, clk, rst_n, s_acc && s_tuser && n_q != '0, state_reg == ST_RD && n_reg == $past(n_q), "query did not enter pair loop")
endmodule
`default_nettype wire
